// ----- design/sse_pkg.sv -----
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants of the spectral SNR estimator
// Field widths, status codes and fixed-point constants.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int MAG_W    = 16;
    localparam int PEAK_W   = 10;
    localparam int GUARD_W  = 10;
    localparam int SIG_W    = 32;
    localparam int NOISE_W  = 42;
    localparam int SNR_W    = 16;
    localparam int STAT_W   = 2;

    // log2 unit: 64-bit operand, Q6.16 result
    localparam int LOG_IN_W = 64;
    localparam int LOG_P_W  = 6;
    localparam int FRAC_W   = 16;
    localparam int LOG_W    = LOG_P_W + FRAC_W;

    localparam int K_W      = 18;
    localparam int SCALE_W  = LOG_W + K_W;

    typedef logic [STAT_W-1:0] status_t;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_PEAK_OUT   = 2'd1;
    localparam status_t ST_SIG_ZERO   = 2'd2;
    localparam status_t ST_NOISE_ZERO = 2'd3;

    localparam logic [GUARD_W-1:0] GUARD_RESET     = 10'd3;
    // round(10*log10(2) * 2^16)
    localparam logic [K_W-1:0]     DB_PER_LOG2_Q16 = 18'd197283;
    localparam logic [SNR_W-1:0]   SNR_LIMIT       = 16'd25600;
    localparam int                 SCALE_SHIFT     = 24;

endpackage

// ----- design/spectral_snr_estimator.sv -----
// ----------------------------------------------------------------------------
// spectral_snr_estimator: SNR of one spectrum frame in 1/256 dB
// Accumulates peak and noise power over a frame of bins, then computes
// 10*log10(signal * noise_count / noise_power) with status.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                    transaction
//  s_        in   tdata: magnitude, peak_index; tlast: last   one spectrum bin
//  m_        out  tdata: snr_db; tuser: status                one result per frame
//  cfg_      in   cfg_wdata: guard_bins                       register write
//
//  Bins are taken one per cycle. A frame end hands its record to a two-entry
//  queue; the SNR path then runs the two shared-nothing log2 units
//  (6 normalization steps, 16 squaring steps each).
//  Input stalls only while the queue holds two unprocessed frames.
//  Synchronous active-low reset; guard_bins resets to 3.
// ----------------------------------------------------------------------------
module spectral_snr_estimator #(
    parameter int MAX_BINS = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [sse_pkg::GUARD_W-1:0]  cfg_wdata,   // guard_bins
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,     // [15:0] magnitude, [25:16] peak_index
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sse_pkg::SNR_W-1:0]    m_tdata,     // [15:0] snr_db
    output logic [sse_pkg::STAT_W-1:0]   m_tuser      // [1:0] status
);
    import sse_pkg::*;

    localparam int IDXW = $clog2(MAX_BINS);
    localparam int CNTW = $clog2(MAX_BINS + 1);
    localparam int RW   = STAT_W + NOISE_W + CNTW + SIG_W;

    logic          q_push, q_pop, q_full, q_empty;
    logic [RW-1:0] q_din, q_dout;

    sse_front #(
        .MAX_BINS (MAX_BINS),
        .IDXW     (IDXW),
        .CNTW     (CNTW),
        .RW       (RW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .magnitude  (s_tdata[MAG_W-1:0]),
        .peak_index (s_tdata[MAG_W +: PEAK_W]),
        .last_bin   (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_din)
    );

    sse_fifo #(
        .DW (RW)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_dout),
        .full    (q_full),
        .empty   (q_empty)
    );

    sse_back #(
        .CNTW (CNTW),
        .RW   (RW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_dout),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_noise_zero_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_NOISE_ZERO |-> m_tdata == SNR_LIMIT)
        else $error("noise-zero result not at full scale");

    a_fault_zero_db: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_PEAK_OUT || m_tuser == ST_SIG_ZERO) |-> m_tdata == '0)
        else $error("fault status with nonzero snr");

    a_snr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= $signed(SNR_LIMIT)) &&
                     ($signed(m_tdata) >= -$signed(SNR_LIMIT)))
        else $error("snr outside saturation range");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_tready)
        else $error("input ready while record queue full");

endmodule

// ----- design/sse_front.sv -----
// ----------------------------------------------------------------------------
// sse_front: bin accumulation
// Takes bins, captures the peak power, sums noise power and pushes one
// frame record (status, noise sum, noise count, signal power) at frame end.
// ----------------------------------------------------------------------------
module sse_front #(
    parameter int MAX_BINS = 1024,
    parameter int IDXW     = 10,
    parameter int CNTW     = 11,
    parameter int RW       = 87
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [sse_pkg::GUARD_W-1:0]  cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sse_pkg::MAG_W-1:0]    magnitude,
    input  logic [sse_pkg::PEAK_W-1:0]   peak_index,
    input  logic                         last_bin,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [RW-1:0]                q_data
);
    import sse_pkg::*;

    localparam int CW = ((IDXW > PEAK_W) ? IDXW : PEAK_W) + 1;

    logic [GUARD_W-1:0] guard_reg;
    logic [IDXW-1:0]    bin_cnt_reg, bin_cnt_next;
    logic [PEAK_W-1:0]  peak_reg, peak_next;
    logic [SIG_W-1:0]   sig_reg, sig_next;
    logic               seen_reg, seen_next;
    logic [NOISE_W-1:0] noise_reg, noise_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;

    logic               accept;
    logic [PEAK_W-1:0]  peak_eff;
    logic [CW-1:0]      idx_w, pk_w, gd_w;
    logic               hit, excluded, last;
    logic [SIG_W-1:0]   sq;
    logic [NOISE_W:0]   nsum;
    logic [SIG_W-1:0]   sig_new;
    logic               seen_new;
    logic [NOISE_W-1:0] noise_new;
    logic [CNTW-1:0]    cnt_new;
    status_t            status;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        peak_eff = (bin_cnt_reg == '0) ? peak_index : peak_reg;
        idx_w    = CW'(bin_cnt_reg);
        pk_w     = CW'(peak_eff);
        gd_w     = CW'(guard_reg);
        hit      = (idx_w == pk_w);
        excluded = (bin_cnt_reg != '0) && (idx_w + gd_w >= pk_w) && (idx_w <= pk_w + gd_w);
        last     = last_bin || (bin_cnt_reg == IDXW'(MAX_BINS - 1));
        sq       = SIG_W'(magnitude) * SIG_W'(magnitude);
        sig_new  = hit ? sq : sig_reg;
        seen_new = seen_reg || hit;
        nsum     = {1'b0, noise_reg} + (NOISE_W + 1)'(sq);
        if (excluded) begin
            noise_new = noise_reg;
            cnt_new   = cnt_reg;
        end else begin
            // saturating noise sum
            noise_new = nsum[NOISE_W] ? {NOISE_W{1'b1}} : nsum[NOISE_W-1:0];
            cnt_new   = cnt_reg + CNTW'(1);
        end
        priority if (!seen_new) begin
            status = ST_PEAK_OUT;
        end else if (sig_new == '0) begin
            status = ST_SIG_ZERO;
        end else if (noise_new == '0) begin
            status = ST_NOISE_ZERO;
        end else begin
            status = ST_OK;
        end
    end

    assign q_push = accept && last;
    assign q_data = {status, noise_new, cnt_new, sig_new};

    always_comb begin
        bin_cnt_next = bin_cnt_reg;
        peak_next    = peak_reg;
        sig_next     = sig_reg;
        seen_next    = seen_reg;
        noise_next   = noise_reg;
        cnt_next     = cnt_reg;
        if (accept) begin
            if (last) begin
                bin_cnt_next = '0;
                peak_next    = '0;
                sig_next     = '0;
                seen_next    = 1'b0;
                noise_next   = '0;
                cnt_next     = '0;
            end else begin
                bin_cnt_next = bin_cnt_reg + IDXW'(1);
                peak_next    = peak_eff;
                sig_next     = sig_new;
                seen_next    = seen_new;
                noise_next   = noise_new;
                cnt_next     = cnt_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg   <= GUARD_RESET;
            bin_cnt_reg <= '0;
            peak_reg    <= '0;
            sig_reg     <= '0;
            seen_reg    <= 1'b0;
            noise_reg   <= '0;
            cnt_reg     <= '0;
        end else begin
            if (cfg_we) begin
                guard_reg <= cfg_wdata;
            end
            bin_cnt_reg <= bin_cnt_next;
            peak_reg    <= peak_next;
            sig_reg     <= sig_next;
            seen_reg    <= seen_next;
            noise_reg   <= noise_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

// ----- design/sse_fifo.sv -----
// ----------------------------------------------------------------------------
// sse_fifo: two-entry frame record queue
// Decouples bin accumulation from the SNR computation.
// ----------------------------------------------------------------------------
module sse_fifo #(
    parameter int DW = 87
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] din,
    input  logic          pop,
    output logic [DW-1:0] dout,
    output logic          full,
    output logic          empty
);
    import sse_pkg::*;

    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- design/sse_log2.sv -----
// ----------------------------------------------------------------------------
// sse_log2: iterative base-2 logarithm
// Six binary normalization steps, then one fraction bit per cycle by
// squaring the Q1.31 mantissa. Result is unsigned Q6.16.
// ----------------------------------------------------------------------------
module sse_log2 (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [sse_pkg::LOG_IN_W-1:0] x,
    output logic                         done,
    output logic [sse_pkg::LOG_W-1:0]    result
);
    import sse_pkg::*;

    localparam logic [1:0] LG_IDLE = 2'd0;
    localparam logic [1:0] LG_NORM = 2'd1;
    localparam logic [1:0] LG_FRAC = 2'd2;

    localparam logic [3:0] NORM_LAST = 4'd5;
    localparam logic [3:0] FRAC_LAST = 4'(FRAC_W - 1);

    logic [1:0]          state_reg;
    logic [3:0]          step_reg;
    logic [LOG_IN_W-1:0] x_reg;
    logic [LOG_P_W-1:0]  p_reg;
    logic [31:0]         m_reg;
    logic [FRAC_W-1:0]   f_reg;
    logic                done_reg;

    logic [LOG_P_W:0]    sh;
    logic                zero_top;
    logic [LOG_IN_W-1:0] norm_x;
    logic [63:0]         prod;

    always_comb begin
        unique case (step_reg[2:0])
            3'd0: begin sh = 7'd32; zero_top = (x_reg[63:32] == '0); end
            3'd1: begin sh = 7'd16; zero_top = (x_reg[63:48] == '0); end
            3'd2: begin sh = 7'd8;  zero_top = (x_reg[63:56] == '0); end
            3'd3: begin sh = 7'd4;  zero_top = (x_reg[63:60] == '0); end
            3'd4: begin sh = 7'd2;  zero_top = (x_reg[63:62] == '0); end
            3'd5: begin sh = 7'd1;  zero_top = !x_reg[63]; end
            default: begin sh = 7'd0; zero_top = 1'b0; end
        endcase
        norm_x = zero_top ? (x_reg << sh) : x_reg;
        prod   = 64'(m_reg) * 64'(m_reg);
    end

    assign done   = done_reg;
    assign result = {p_reg, f_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LG_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                LG_IDLE: begin
                    if (start) begin
                        state_reg <= LG_NORM;
                        step_reg  <= '0;
                    end
                end
                LG_NORM: begin
                    if (step_reg == NORM_LAST) begin
                        state_reg <= LG_FRAC;
                        step_reg  <= '0;
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                LG_FRAC: begin
                    if (step_reg == FRAC_LAST) begin
                        state_reg <= LG_IDLE;
                        done_reg  <= 1'b1;
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                default: begin
                    state_reg <= LG_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == LG_IDLE && start) begin
            x_reg <= x;
            p_reg <= {LOG_P_W{1'b1}};
            f_reg <= '0;
        end else if (state_reg == LG_NORM) begin
            x_reg <= norm_x;
            if (zero_top) begin
                p_reg <= p_reg - sh[LOG_P_W-1:0];
            end
            if (step_reg == NORM_LAST) begin
                m_reg <= norm_x[63:32];
            end
        end else if (state_reg == LG_FRAC) begin
            // m*m >> 31 reaching 2 sets the bit and halves
            f_reg <= {f_reg[FRAC_W-2:0], prod[63]};
            m_reg <= prod[63] ? prod[63:32] : prod[62:31];
        end
    end

endmodule

// ----- design/sse_back.sv -----
// ----------------------------------------------------------------------------
// sse_back: SNR computation
// Pops a frame record; for status OK forms log2(signal*count) - log2(noise),
// scales to 1/256 dB, rounds, saturates and holds it in the output register.
// ----------------------------------------------------------------------------
module sse_back #(
    parameter int CNTW = 11,
    parameter int RW   = 87
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  logic [RW-1:0]              q_data,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sse_pkg::SNR_W-1:0]  m_tdata,
    output logic [sse_pkg::STAT_W-1:0] m_tuser
);
    import sse_pkg::*;

    localparam int NUMW = SIG_W + CNTW;

    localparam logic [2:0] BK_IDLE  = 3'd0;
    localparam logic [2:0] BK_MUL   = 3'd1;
    localparam logic [2:0] BK_LOG   = 3'd2;
    localparam logic [2:0] BK_WAIT  = 3'd3;
    localparam logic [2:0] BK_SCALE = 3'd4;

    logic [2:0]         state_reg;
    logic [SIG_W-1:0]   sig_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [NOISE_W-1:0] den_reg;
    logic [NUMW-1:0]    num_reg;
    logic [SCALE_W-1:0] prod_reg;
    logic               neg_reg;

    logic               out_valid_reg;
    logic [SNR_W-1:0]   out_data_reg;
    status_t            out_user_reg;

    status_t            rec_status;
    logic               out_free, out_load;
    logic [SNR_W-1:0]   load_data;
    status_t            load_user;

    logic               num_done, den_done;
    logic [LOG_W-1:0]   ln, ld;
    logic               neg;
    logic [LOG_W-1:0]   dabs;
    logic [SCALE_W:0]   rsum;
    logic [SCALE_W-SCALE_SHIFT:0] mag;
    logic [SNR_W-1:0]   mag_sat;

    assign rec_status = q_data[RW-1 -: STAT_W];
    assign out_free   = !out_valid_reg || m_tready;

    assign q_pop = (state_reg == BK_IDLE) && !q_empty &&
                   ((rec_status == ST_OK) || out_free);

    sse_log2 u_log_num (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == BK_LOG),
        .x       (LOG_IN_W'(num_reg)),
        .done    (num_done),
        .result  (ln)
    );

    sse_log2 u_log_den (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == BK_LOG),
        .x       (LOG_IN_W'(den_reg)),
        .done    (den_done),
        .result  (ld)
    );

    always_comb begin
        neg     = (ln < ld);
        dabs    = neg ? (ld - ln) : (ln - ld);
        rsum    = (SCALE_W + 1)'(prod_reg) + ((SCALE_W + 1)'(1) << (SCALE_SHIFT - 1));
        mag     = rsum[SCALE_W:SCALE_SHIFT];
        mag_sat = (mag > (SCALE_W - SCALE_SHIFT + 1)'(SNR_LIMIT)) ? SNR_LIMIT
                                                                  : SNR_W'(mag);
    end

    always_comb begin
        out_load  = 1'b0;
        load_data = '0;
        load_user = ST_OK;
        if (q_pop && rec_status != ST_OK) begin
            out_load  = 1'b1;
            load_user = rec_status;
            load_data = (rec_status == ST_NOISE_ZERO) ? SNR_LIMIT : '0;
        end else if (state_reg == BK_SCALE && out_free) begin
            out_load  = 1'b1;
            load_user = ST_OK;
            load_data = neg_reg ? (SNR_W'(0) - mag_sat) : mag_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                BK_IDLE: begin
                    if (q_pop && rec_status == ST_OK) begin
                        state_reg <= BK_MUL;
                    end
                end
                BK_MUL: begin
                    state_reg <= BK_LOG;
                end
                BK_LOG: begin
                    state_reg <= BK_WAIT;
                end
                BK_WAIT: begin
                    if (num_done && den_done) begin
                        state_reg <= BK_SCALE;
                    end
                end
                BK_SCALE: begin
                    if (out_free) begin
                        state_reg <= BK_IDLE;
                    end
                end
                default: begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sig_reg <= q_data[SIG_W-1:0];
            cnt_reg <= q_data[SIG_W +: CNTW];
            den_reg <= q_data[SIG_W + CNTW +: NOISE_W];
        end
        if (state_reg == BK_MUL) begin
            num_reg <= NUMW'(sig_reg) * NUMW'(cnt_reg);
        end
        if (state_reg == BK_WAIT) begin
            prod_reg <= SCALE_W'(dabs) * SCALE_W'(DB_PER_LOG2_Q16);
            neg_reg  <= neg;
        end
        if (out_load) begin
            out_data_reg <= load_data;
            out_user_reg <= load_user;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
